@@ rtl/pcht_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the point capsule hit test.
// No dependencies; used by the input interface, the pipeline and the checker.
package pcht_pkg;

  // Radius fields are fixed at 23 bits, unsigned Q15.8
  localparam int RADIUS_WIDTH = 23;
  // Radius sum and its square
  localparam int RSUM_W       = RADIUS_WIDTH + 1;
  localparam int R2_W         = 2 * RSUM_W;

  // Register stages between the input word and the result register
  localparam int PIPE_DEPTH   = 8;

  // Nearest part of the segment
  typedef enum logic [1:0] {
    REGION_INTERIOR = 2'd0,
    REGION_END_A    = 2'd1,
    REGION_END_B    = 2'd2
  } region_t;

endpackage

@@ rtl/pcht_in_if.sv @@
`timescale 1ns / 1ps
// Input channel: one query word (segment ends, point, two radii).
// Depends on pcht_pkg for the radius width.
interface pcht_in_if #(
  parameter int COORD_WIDTH = 24
);
  logic                                  valid;
  logic                                  ready;
  logic signed [COORD_WIDTH-1:0]         seg_a_x;
  logic signed [COORD_WIDTH-1:0]         seg_a_y;
  logic signed [COORD_WIDTH-1:0]         seg_a_z;
  logic signed [COORD_WIDTH-1:0]         seg_b_x;
  logic signed [COORD_WIDTH-1:0]         seg_b_y;
  logic signed [COORD_WIDTH-1:0]         seg_b_z;
  logic signed [COORD_WIDTH-1:0]         point_x;
  logic signed [COORD_WIDTH-1:0]         point_y;
  logic signed [COORD_WIDTH-1:0]         point_z;
  logic [pcht_pkg::RADIUS_WIDTH-1:0]     radius_one;
  logic [pcht_pkg::RADIUS_WIDTH-1:0]     radius_two;

  modport source (
    output valid, seg_a_x, seg_a_y, seg_a_z, seg_b_x, seg_b_y, seg_b_z,
           point_x, point_y, point_z, radius_one, radius_two,
    input  ready
  );
  modport sink (
    input  valid, seg_a_x, seg_a_y, seg_a_z, seg_b_x, seg_b_y, seg_b_z,
           point_x, point_y, point_z, radius_one, radius_two,
    output ready
  );
endinterface

@@ rtl/pcht_out_if.sv @@
`timescale 1ns / 1ps
// Result channel: hit flag and nearest region per query word.
// No package dependencies.
interface pcht_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] region;

  modport source (output valid, hit, region, input ready);
  modport sink   (input valid, hit, region, output ready);
endinterface

@@ rtl/point_capsule_hit_test.sv @@
`timescale 1ns / 1ps
// Point against capsule hit test, exact fixed-point, eight-stage pipeline.
// Depends on pcht_pkg, pcht_in_if, pcht_out_if and pcht_mul.

// One query word enters per clock while the output is not stalled. Every
// stage has its own valid bit and moves when it is empty or the stage after
// it moves, so back-pressure fills bubbles first and only then drops
// in_ch.ready. Stages: coordinate differences, the fifteen coordinate
// products and the radius-sum square, dot sums, region choice and end-point
// compare, two stages for the three wide products (split into half-width
// partial products), the interior difference, and the final compare. All
// math is exact on squared quantities: no division, no root, no rounding.
// A degenerate segment (A equal to B) reports end A. No reset-time sweep.
module point_capsule_hit_test #(
  parameter int COORD_WIDTH = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  pcht_in_if.sink    in_ch,
  pcht_out_if.source out_ch
);

  localparam int DEPTH  = pcht_pkg::PIPE_DEPTH;
  localparam int DW     = COORD_WIDTH + 1;          // coordinate difference
  localparam int PROD_W = 2 * DW;                   // coordinate product
  localparam int SUM_W  = 2 * COORD_WIDTH + 3;      // signed dot product
  localparam int MW     = 2 * COORD_WIDTH + 2;      // squared length
  localparam int MUL_W  = (MW > pcht_pkg::R2_W) ? MW : pcht_pkg::R2_W;
  localparam int WIDE_W = 2 * MUL_W;

  // stage handshake
  logic [DEPTH:1] stage_en;
  logic [DEPTH:1] valid_r, valid_nxt;

  always_comb begin
    stage_en[DEPTH] = !valid_r[DEPTH] || out_ch.ready;
    for (int k = DEPTH - 1; k >= 1; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (stage_en[1]) valid_nxt[1] = in_ch.valid;
    for (int k = 2; k <= DEPTH; k++) begin
      if (stage_en[k]) valid_nxt[k] = valid_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ch.ready = stage_en[1];

  // stage 1: differences P-A, P-B, B-A and radius sum
  logic signed [COORD_WIDTH-1:0] a_in [3];
  logic signed [COORD_WIDTH-1:0] b_in [3];
  logic signed [COORD_WIDTH-1:0] p_in [3];

  assign a_in[0] = in_ch.seg_a_x;
  assign a_in[1] = in_ch.seg_a_y;
  assign a_in[2] = in_ch.seg_a_z;
  assign b_in[0] = in_ch.seg_b_x;
  assign b_in[1] = in_ch.seg_b_y;
  assign b_in[2] = in_ch.seg_b_z;
  assign p_in[0] = in_ch.point_x;
  assign p_in[1] = in_ch.point_y;
  assign p_in[2] = in_ch.point_z;

  logic signed [DW-1:0]            s1_pa_r [3];
  logic signed [DW-1:0]            s1_pb_r [3];
  logic signed [DW-1:0]            s1_ba_r [3];
  logic [pcht_pkg::RSUM_W-1:0]     s1_rsum_r;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_pa_r[i] <= DW'(p_in[i]) - DW'(a_in[i]);
        s1_pb_r[i] <= DW'(p_in[i]) - DW'(b_in[i]);
        s1_ba_r[i] <= DW'(b_in[i]) - DW'(a_in[i]);
      end
      s1_rsum_r <= pcht_pkg::RSUM_W'(in_ch.radius_one)
                 + pcht_pkg::RSUM_W'(in_ch.radius_two);
    end
  end

  // stage 2: per-axis products
  logic signed [PROD_W-1:0]        s2_pa_ba_r [3];
  logic signed [PROD_W-1:0]        s2_pb_ba_r [3];
  logic signed [PROD_W-1:0]        s2_ba_ba_r [3];
  logic signed [PROD_W-1:0]        s2_pa_pa_r [3];
  logic signed [PROD_W-1:0]        s2_pb_pb_r [3];
  logic [pcht_pkg::R2_W-1:0]       s2_r2_r;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      for (int i = 0; i < 3; i++) begin
        s2_pa_ba_r[i] <= s1_pa_r[i] * s1_ba_r[i];
        s2_pb_ba_r[i] <= s1_pb_r[i] * s1_ba_r[i];
        s2_ba_ba_r[i] <= s1_ba_r[i] * s1_ba_r[i];
        s2_pa_pa_r[i] <= s1_pa_r[i] * s1_pa_r[i];
        s2_pb_pb_r[i] <= s1_pb_r[i] * s1_pb_r[i];
      end
      s2_r2_r <= s1_rsum_r * s1_rsum_r;
    end
  end

  // stage 3: dot sums; the three squared lengths are never negative
  logic signed [SUM_W-1:0] along_a_sum, along_b_sum, len2_sum, pa2_sum, pb2_sum;

  always_comb begin
    along_a_sum = SUM_W'(s2_pa_ba_r[0]) + SUM_W'(s2_pa_ba_r[1]) + SUM_W'(s2_pa_ba_r[2]);
    along_b_sum = SUM_W'(s2_pb_ba_r[0]) + SUM_W'(s2_pb_ba_r[1]) + SUM_W'(s2_pb_ba_r[2]);
    len2_sum    = SUM_W'(s2_ba_ba_r[0]) + SUM_W'(s2_ba_ba_r[1]) + SUM_W'(s2_ba_ba_r[2]);
    pa2_sum     = SUM_W'(s2_pa_pa_r[0]) + SUM_W'(s2_pa_pa_r[1]) + SUM_W'(s2_pa_pa_r[2]);
    pb2_sum     = SUM_W'(s2_pb_pb_r[0]) + SUM_W'(s2_pb_pb_r[1]) + SUM_W'(s2_pb_pb_r[2]);
  end

  logic signed [SUM_W-1:0]   s3_along_a_r;
  logic signed [SUM_W-1:0]   s3_along_b_r;   // dot(P-B, B-A): positive means past B
  logic [MW-1:0]             s3_len2_r;
  logic [MW-1:0]             s3_pa2_r;
  logic [MW-1:0]             s3_pb2_r;
  logic [pcht_pkg::R2_W-1:0] s3_r2_r;

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s3_along_a_r <= along_a_sum;
      s3_along_b_r <= along_b_sum;
      s3_len2_r    <= len2_sum[MW-1:0];
      s3_pa2_r     <= pa2_sum[MW-1:0];
      s3_pb2_r     <= pb2_sum[MW-1:0];
      s3_r2_r      <= s2_r2_r;
    end
  end

  // stage 4: region choice, end-point compare, wide multiplier operands
  pcht_pkg::region_t region_nxt;
  logic              end_hit_nxt;

  always_comb begin
    priority if (s3_len2_r == '0 || s3_along_a_r[SUM_W-1]) begin
      region_nxt = pcht_pkg::REGION_END_A;
    end else if (!s3_along_b_r[SUM_W-1] && s3_along_b_r != '0) begin
      region_nxt = pcht_pkg::REGION_END_B;
    end else begin
      region_nxt = pcht_pkg::REGION_INTERIOR;
    end
  end

  always_comb begin
    if (region_nxt == pcht_pkg::REGION_END_B) begin
      end_hit_nxt = MUL_W'(s3_pb2_r) < MUL_W'(s3_r2_r);
    end else begin
      end_hit_nxt = MUL_W'(s3_pa2_r) < MUL_W'(s3_r2_r);
    end
  end

  pcht_pkg::region_t s4_region_r;
  logic              s4_end_hit_r;
  logic [MUL_W-1:0]  s4_pa2_r;
  logic [MUL_W-1:0]  s4_len2_r;
  logic [MUL_W-1:0]  s4_along_r;    // only used for the interior, where it is >= 0
  logic [MUL_W-1:0]  s4_r2_r;

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s4_region_r  <= region_nxt;
      s4_end_hit_r <= end_hit_nxt;
      s4_pa2_r     <= MUL_W'(s3_pa2_r);
      s4_len2_r    <= MUL_W'(s3_len2_r);
      s4_along_r   <= MUL_W'(s3_along_a_r[MW-1:0]);
      s4_r2_r      <= MUL_W'(s3_r2_r);
    end
  end

  // stages 5-6: |P-A|^2 * |v|^2, dot^2, R^2 * |v|^2
  logic [WIDE_W-1:0] pa2_len2, along_sq, r2_len2;

  pcht_mul #(.OP_W(MUL_W)) u_mul_pa2_len2 (
    .clk      (clk),
    .stage_en (stage_en[6:5]),
    .op_a     (s4_pa2_r),
    .op_b     (s4_len2_r),
    .prod     (pa2_len2)
  );

  pcht_mul #(.OP_W(MUL_W)) u_mul_along_sq (
    .clk      (clk),
    .stage_en (stage_en[6:5]),
    .op_a     (s4_along_r),
    .op_b     (s4_along_r),
    .prod     (along_sq)
  );

  pcht_mul #(.OP_W(MUL_W)) u_mul_r2_len2 (
    .clk      (clk),
    .stage_en (stage_en[6:5]),
    .op_a     (s4_r2_r),
    .op_b     (s4_len2_r),
    .prod     (r2_len2)
  );

  // side data rides along with the multipliers
  pcht_pkg::region_t s5_region_r, s6_region_r;
  logic              s5_end_hit_r, s6_end_hit_r;

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      s5_region_r  <= s4_region_r;
      s5_end_hit_r <= s4_end_hit_r;
    end
    if (stage_en[6]) begin
      s6_region_r  <= s5_region_r;
      s6_end_hit_r <= s5_end_hit_r;
    end
  end

  // stage 7: squared perpendicular distance times |v|^2
  pcht_pkg::region_t s7_region_r;
  logic              s7_end_hit_r;
  logic [WIDE_W-1:0] s7_lhs_r;
  logic [WIDE_W-1:0] s7_rhs_r;

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      s7_region_r  <= s6_region_r;
      s7_end_hit_r <= s6_end_hit_r;
      s7_lhs_r     <= pa2_len2 - along_sq;
      s7_rhs_r     <= r2_len2;
    end
  end

  // stage 8: final compare into the result register
  logic hit_nxt;

  always_comb begin
    unique case (s7_region_r)
      pcht_pkg::REGION_INTERIOR: hit_nxt = s7_lhs_r < s7_rhs_r;
      pcht_pkg::REGION_END_A:    hit_nxt = s7_end_hit_r;
      pcht_pkg::REGION_END_B:    hit_nxt = s7_end_hit_r;
      default:                   hit_nxt = 1'b0;
    endcase
  end

  pcht_pkg::region_t s8_region_r;
  logic              s8_hit_r;

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      s8_region_r <= s7_region_r;
      s8_hit_r    <= hit_nxt;
    end
  end

  assign out_ch.valid  = valid_r[DEPTH];
  assign out_ch.hit    = s8_hit_r;
  assign out_ch.region = s8_region_r;

endmodule

@@ rtl/pcht_mul.sv @@
`timescale 1ns / 1ps
// Two-stage unsigned multiplier: half-width partial products, then their sum.
// Stand-alone; stage enables come from the pipeline that owns the valid bits.
module pcht_mul #(
  parameter int OP_W = 50
) (
  input  logic                clk,
  input  logic [1:0]          stage_en,   // [0] partial products, [1] sum
  input  logic [OP_W-1:0]     op_a,
  input  logic [OP_W-1:0]     op_b,
  output logic [2*OP_W-1:0]   prod
);

  localparam int LO_W = (OP_W + 1) / 2;
  localparam int HI_W = OP_W - LO_W;
  localparam int P_W  = 2 * OP_W;

  logic [2*LO_W-1:0]    pp_ll_r, pp_ll_nxt;
  logic [LO_W+HI_W-1:0] pp_lh_r, pp_lh_nxt;
  logic [LO_W+HI_W-1:0] pp_hl_r, pp_hl_nxt;
  logic [2*HI_W-1:0]    pp_hh_r, pp_hh_nxt;
  logic [P_W-1:0]       prod_r, prod_nxt;

  // partial products of the operand halves
  always_comb begin
    pp_ll_nxt = op_a[LO_W-1:0]    * op_b[LO_W-1:0];
    pp_lh_nxt = op_a[LO_W-1:0]    * op_b[OP_W-1:LO_W];
    pp_hl_nxt = op_a[OP_W-1:LO_W] * op_b[LO_W-1:0];
    pp_hh_nxt = op_a[OP_W-1:LO_W] * op_b[OP_W-1:LO_W];
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      pp_ll_r <= pp_ll_nxt;
      pp_lh_r <= pp_lh_nxt;
      pp_hl_r <= pp_hl_nxt;
      pp_hh_r <= pp_hh_nxt;
    end
  end

  // align and add
  always_comb begin
    prod_nxt = (P_W'(pp_hh_r) << (2 * LO_W))
             + ((P_W'(pp_lh_r) + P_W'(pp_hl_r)) << LO_W)
             + P_W'(pp_ll_r);
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

@@ rtl/pcht_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for point_capsule_hit_test, bound to the top level.
// Depends on pcht_pkg for the pipeline depth and region codes.
module pcht_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_hit,
  input logic [1:0] out_region
);

  localparam int CNT_W = $clog2(pcht_pkg::PIPE_DEPTH + 1);

  // words accepted but not yet delivered
  logic [CNT_W-1:0] pending_r, pending_nxt;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !out_acc) pending_nxt = pending_r + CNT_W'(1);
    if (!in_acc && out_acc) pending_nxt = pending_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit) && $stable(out_region))
    else $error("result payload changed while stalled");

  // no result without an accepted query behind it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("result word with no pending query");

  // the pipeline never takes more words than it has stages
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pending_r < CNT_W'(pcht_pkg::PIPE_DEPTH) || out_acc)
    else $error("query accepted beyond pipeline capacity");

  // region code is one of the three defined values
  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_region == pcht_pkg::REGION_INTERIOR
               || out_region == pcht_pkg::REGION_END_A
               || out_region == pcht_pkg::REGION_END_B)
    else $error("undefined region code on result");

endmodule

bind point_capsule_hit_test pcht_checker u_pcht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_hit    (out_ch.hit),
  .out_region (out_ch.region)
);

@@ verif/pcht_hit_checker.sv @@
`timescale 1ns / 1ps
// Checker for the point capsule hit test: predicts each result word from the query word.
// Depends on pcht_pkg, pcht_in_if and pcht_out_if; instantiated by point_capsule_hit_test_tb.
module pcht_hit_checker #(
  parameter int COORD_WIDTH = 24
) (
  input  logic clk,
  input  logic rst_n,
  pcht_in_if   in_ch,
  pcht_out_if  out_ch,
  output int   miscompares,
  output int   outstanding
);

  // 128 bits hold every product here exactly (largest is about 2^99)
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic              hit;
    pcht_pkg::region_t region;
  } hit_word_t;

  hit_word_t predicted_hits[$];
  int        fail_total = 0;

  function automatic wide_t widen(input logic [COORD_WIDTH-1:0] c);
    return {{(128-COORD_WIDTH){c[COORD_WIDTH-1]}}, c};
  endfunction

  function automatic wide_t dot3(input wide_t x[3], input wide_t y[3]);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  // Exact squared-distance test against the capsule of radius r1 + r2
  function automatic hit_word_t predict_capsule_hit(
    input logic [COORD_WIDTH-1:0]            ax, ay, az, bx, by, bz, px, py, pz,
    input logic [pcht_pkg::RADIUS_WIDTH-1:0] r1, r2
  );
    wide_t     a[3], b[3], p[3], pa[3], pb[3], ba[3], ab[3];
    wide_t     along_a, along_b, len2, rsum, r_sq, pa_sq, pb_sq;
    hit_word_t w;
    a[0] = widen(ax); a[1] = widen(ay); a[2] = widen(az);
    b[0] = widen(bx); b[1] = widen(by); b[2] = widen(bz);
    p[0] = widen(px); p[1] = widen(py); p[2] = widen(pz);
    for (int i = 0; i < 3; i++) begin
      pa[i] = p[i] - a[i];
      pb[i] = p[i] - b[i];
      ba[i] = b[i] - a[i];
      ab[i] = a[i] - b[i];
    end
    rsum    = {{(128-pcht_pkg::RADIUS_WIDTH){1'b0}}, r1}
            + {{(128-pcht_pkg::RADIUS_WIDTH){1'b0}}, r2};
    r_sq    = rsum * rsum;
    along_a = dot3(pa, ba);
    along_b = dot3(pb, ab);
    len2    = dot3(ba, ba);
    pa_sq   = dot3(pa, pa);
    pb_sq   = dot3(pb, pb);
    // zero-length segment falls into the end A case
    if (len2 == 0 || along_a < 0) begin
      w.region = pcht_pkg::REGION_END_A;
      w.hit    = (pa_sq < r_sq);
    end else if (along_b < 0) begin
      w.region = pcht_pkg::REGION_END_B;
      w.hit    = (pb_sq < r_sq);
    end else begin
      w.region = pcht_pkg::REGION_INTERIOR;
      w.hit    = (pa_sq * len2 - along_a * along_a < r_sq * len2);
    end
    return w;
  endfunction

  // Compare accepted results, then queue the prediction for an accepted query
  always @(posedge clk) begin : watch
    hit_word_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_hits.size() == 0) begin
          $display("%0t: result word with nothing expected: hit %b region %0d", $time,
                   out_ch.hit, out_ch.region);
          fail_total++;
        end else begin
          want = predicted_hits.pop_front();
          if (out_ch.hit !== want.hit) begin
            $display("%0t: hit mismatch: expected %b actual %b", $time, want.hit, out_ch.hit);
            fail_total++;
          end
          if (out_ch.region !== want.region) begin
            $display("%0t: region mismatch: expected %0d actual %0d", $time, want.region,
                     out_ch.region);
            fail_total++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_hits.push_back(predict_capsule_hit(
          in_ch.seg_a_x, in_ch.seg_a_y, in_ch.seg_a_z,
          in_ch.seg_b_x, in_ch.seg_b_y, in_ch.seg_b_z,
          in_ch.point_x, in_ch.point_y, in_ch.point_z,
          in_ch.radius_one, in_ch.radius_two));
      end
    end
    miscompares <= fail_total;
    outstanding <= predicted_hits.size();
  end

endmodule

@@ verif/point_capsule_hit_test_tb.sv @@
`timescale 1ns / 1ps
// Top of the point capsule hit test bench: clock, reset, query stimulus, drain stalls, verdict.
// Depends on pcht_pkg, both channel interfaces, the block and pcht_hit_checker.
module point_capsule_hit_test_tb;

  localparam int CW          = 24;
  localparam int MINC        = -(2 ** (CW - 1));
  localparam int MAXC        = 2 ** (CW - 1) - 1;
  localparam int RMAX        = 2 ** pcht_pkg::RADIUS_WIDTH - 1;
  localparam int N_RANDOM    = 1800;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 600000;

  typedef struct packed {
    logic [CW-1:0]                     ax, ay, az, bx, by, bz, px, py, pz;
    logic [pcht_pkg::RADIUS_WIDTH-1:0] r1, r2;
  } query_t;

  typedef enum {Q_NOISE, Q_CLUSTER, Q_POINT_SEG, Q_EDGE, Q_NO_RADIUS, Q_HUGE_RADIUS} shape_t;
  typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE, DRAIN_PERIODIC} drain_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic hold_req;
  int   miscompares;
  int   outstanding;
  int   burst_left = 0;

  pcht_in_if #(.COORD_WIDTH(CW)) in_ch();
  pcht_out_if                    out_ch();

  point_capsule_hit_test #(.COORD_WIDTH(CW)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pcht_hit_checker #(.COORD_WIDTH(CW)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .miscompares (miscompares),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  function automatic logic [CW-1:0] to_coord(input int v);
    logic [31:0] w;
    w = v;
    return w[CW-1:0];
  endfunction

  function automatic logic [pcht_pkg::RADIUS_WIDTH-1:0] to_radius(input int v);
    logic [31:0] w;
    w = v;
    return w[pcht_pkg::RADIUS_WIDTH-1:0];
  endfunction

  function automatic logic [CW-1:0] shift_coord(input logic [CW-1:0] c, input int off);
    logic [31:0] s;
    s = 32'(c) + 32'(off);
    return s[CW-1:0];
  endfunction

  // signed offset in [-2^k, 2^k]
  function automatic int rand_offset(input int k);
    return int'($urandom_range(0, 2 ** (k + 1))) - 2 ** k;
  endfunction

  function automatic query_t mk_query(input int ax, ay, az, bx, by, bz, px, py, pz, r1, r2);
    query_t q;
    q.ax = to_coord(ax); q.ay = to_coord(ay); q.az = to_coord(az);
    q.bx = to_coord(bx); q.by = to_coord(by); q.bz = to_coord(bz);
    q.px = to_coord(px); q.py = to_coord(py); q.pz = to_coord(pz);
    q.r1 = to_radius(r1);
    q.r2 = to_radius(r2);
    return q;
  endfunction

  // Mostly clustered geometry so hits and misses both occur; the rest is noise
  function automatic query_t random_query();
    query_t        q;
    shape_t        shape;
    int            pick, k, len, d, t, rsum, split;
    logic [CW-1:0] bx0, by0, bz0;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1:       shape = Q_NOISE;
      2, 3, 4, 5: shape = Q_CLUSTER;
      6:          shape = Q_POINT_SEG;
      7:          shape = Q_EDGE;
      8:          shape = Q_NO_RADIUS;
      default:    shape = Q_HUGE_RADIUS;
    endcase
    k   = $urandom_range(1, 20);
    bx0 = to_coord($urandom());
    by0 = to_coord($urandom());
    bz0 = to_coord($urandom());
    q.ax = shift_coord(bx0, rand_offset(k));
    q.ay = shift_coord(by0, rand_offset(k));
    q.az = shift_coord(bz0, rand_offset(k));
    q.bx = shift_coord(bx0, rand_offset(k));
    q.by = shift_coord(by0, rand_offset(k));
    q.bz = shift_coord(bz0, rand_offset(k));
    q.px = shift_coord(bx0, rand_offset(k));
    q.py = shift_coord(by0, rand_offset(k));
    q.pz = shift_coord(bz0, rand_offset(k));
    q.r1 = to_radius($urandom_range(0, 2 ** k));
    q.r2 = to_radius($urandom_range(0, 2 ** k));
    case (shape)
      Q_NOISE: begin
        q.ax = to_coord($urandom()); q.ay = to_coord($urandom()); q.az = to_coord($urandom());
        q.bx = to_coord($urandom()); q.by = to_coord($urandom()); q.bz = to_coord($urandom());
        q.px = to_coord($urandom()); q.py = to_coord($urandom()); q.pz = to_coord($urandom());
        q.r1 = to_radius($urandom());
        q.r2 = to_radius($urandom());
      end
      Q_POINT_SEG: begin
        q.bx = q.ax; q.by = q.ay; q.bz = q.az;
      end
      Q_EDGE: begin
        // axis-aligned segment, point at or next to the surface
        len  = $urandom_range(1, 4096);
        d    = $urandom_range(0, 4096);
        t    = $urandom_range(0, len);
        q.ax = bx0; q.ay = by0; q.az = bz0;
        q.bx = shift_coord(bx0, len); q.by = by0; q.bz = bz0;
        q.py = by0; q.pz = bz0;
        case ($urandom_range(0, 2))
          0: begin
            q.px = shift_coord(bx0, t);
            q.py = shift_coord(by0, ($urandom_range(0, 1) != 0) ? d : -d);
          end
          1:       q.px = shift_coord(bx0, -d);
          default: q.px = shift_coord(bx0, len + d);
        endcase
        rsum = d + int'($urandom_range(0, 2)) - 1;
        if (rsum < 0) rsum = 0;
        split = $urandom_range(0, rsum);
        q.r1  = to_radius(split);
        q.r2  = to_radius(rsum - split);
      end
      Q_NO_RADIUS: begin
        q.r1 = '0;
        q.r2 = '0;
      end
      Q_HUGE_RADIUS: begin
        q.r1 = to_radius(RMAX - int'($urandom_range(0, 255)));
        q.r2 = to_radius(RMAX - int'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    return q;
  endfunction

  // Offer one query word; bursts of random length separated by random gaps
  task automatic send_query(input query_t q);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.seg_a_x    <= q.ax;
    in_ch.seg_a_y    <= q.ay;
    in_ch.seg_a_z    <= q.az;
    in_ch.seg_b_x    <= q.bx;
    in_ch.seg_b_y    <= q.by;
    in_ch.seg_b_z    <= q.bz;
    in_ch.point_x    <= q.px;
    in_ch.point_y    <= q.py;
    in_ch.point_z    <= q.pz;
    in_ch.radius_one <= q.r1;
    in_ch.radius_two <= q.r2;
    in_ch.valid      <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Result drain: stall pattern changes every stretch, one long hold-off on request
  initial begin : drain
    drain_mode_t mode;
    int          stretch, period, phase;
    bit          hold_done;
    hold_done = 1'b0;
    phase     = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      mode    = drain_mode_t'($urandom_range(0, 3));
      stretch = $urandom_range(10, 150);
      period  = $urandom_range(2, 7);
      for (int i = 0; i < stretch; i++) begin
        if (hold_req && !hold_done) begin
          hold_done = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        phase++;
        case (mode)
          DRAIN_FREE:     out_ch.ready <= 1'b1;
          DRAIN_COIN:     out_ch.ready <= ($urandom_range(0, 1) != 0);
          DRAIN_SPARSE:   out_ch.ready <= ($urandom_range(0, 5) == 0);
          DRAIN_PERIODIC: out_ch.ready <= ((phase % period) != 0);
          default:        out_ch.ready <= 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  // Run guard
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Reset, directed queries, random queries, drain and verdict
  initial begin : stimulus
    rst_n            <= 1'b0;
    hold_req         <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.seg_a_x    <= '0;
    in_ch.seg_a_y    <= '0;
    in_ch.seg_a_z    <= '0;
    in_ch.seg_b_x    <= '0;
    in_ch.seg_b_y    <= '0;
    in_ch.seg_b_z    <= '0;
    in_ch.point_x    <= '0;
    in_ch.point_y    <= '0;
    in_ch.point_z    <= '0;
    in_ch.radius_one <= '0;
    in_ch.radius_two <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-length segment, zero radii, then exact and just-inside point tests
    send_query(mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(100, -200, 300, 100, -200, 300, 100, -200, 300, 1, 0));
    send_query(mk_query(0, 0, 0, 0, 0, 0, 768, 0, 0, 512, 256));
    send_query(mk_query(0, 0, 0, 0, 0, 0, 768, 0, 0, 512, 257));
    // beyond end A, on the surface and just inside
    send_query(mk_query(0, 0, 0, 2560, 0, 0, -100, 0, 0, 100, 0));
    send_query(mk_query(0, 0, 0, 2560, 0, 0, -100, 0, 0, 101, 0));
    // beyond end B
    send_query(mk_query(0, 0, 0, 2560, 0, 0, 2660, 0, 0, 50, 50));
    send_query(mk_query(0, 0, 0, 2560, 0, 0, 2660, 0, 0, 50, 51));
    // interior, distance 500
    send_query(mk_query(0, 0, 0, 2560, 0, 0, 1280, 300, -400, 250, 250));
    send_query(mk_query(0, 0, 0, 2560, 0, 0, 1280, 300, -400, 250, 251));
    // point at end A projects to the interior side
    send_query(mk_query(5, 6, 7, 900, -40, 33, 5, 6, 7, 0, 0));
    send_query(mk_query(5, 6, 7, 900, -40, 33, 5, 6, 7, 0, 1));
    // coordinate and radius extremes
    send_query(mk_query(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, RMAX, RMAX));
    send_query(mk_query(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC, 0, 0));
    send_query(mk_query(MINC, MINC, MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC, RMAX, RMAX));
    send_query(mk_query(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, RMAX, RMAX));
    send_query(mk_query(MINC, 0, MAXC, MAXC, 0, MINC, 0, MAXC, 0, RMAX, RMAX));
    send_query(mk_query(MINC, MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC, 0, RMAX, 0));
    send_query(mk_query(MINC, MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC, 0, 0, RMAX));
    send_query(mk_query(-1000, -1000, -1000, -500, -1000, -1000, -2000, -900, -1000,
                        RMAX, RMAX));
    send_query(mk_query(MINC, MINC, MINC, 0, 0, 0, MAXC, MAXC, MAXC, 0, 0));
    send_query(mk_query(-1, -1, -1, 1, 1, 1, 0, 0, 0, 0, 1));

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == HOLD_AT) hold_req <= 1'b1;
      send_query(random_query());
    end
    in_ch.valid <= 1'b0;

    // drain, then give the pipeline time to show any stray word
    do @(posedge clk); while (outstanding != 0);
    repeat (4 * pcht_pkg::PIPE_DEPTH) @(posedge clk);
    if (miscompares == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
